@@ design/rzspan_pkg.sv @@
package rzspan_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int FRACTION_BITS = 8;

  localparam int ACC_W   = 24;
  localparam int STEP_W  = 11;
  localparam int MUL_B_W = 11;
  localparam int PROD_W  = STEP_W + MUL_B_W + 1;

  // quotient bits kept by the divider; anything at or above 2**QW saturates
  localparam int QW    = $clog2(SCREEN_WIDTH);
  localparam int CNT_W = $clog2(QW + 1);

  localparam int ROW_W = 8;
  localparam int X_W   = 9;
  localparam int UF_W  = 17;
  localparam int VF_W  = 16;

  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;

  localparam logic [ACC_W-1:0] LIM_U_M1 =
    ACC_W'((SCREEN_WIDTH << FRACTION_BITS) - 1);
  localparam logic [ACC_W-1:0] LIM_V_M1 =
    ACC_W'((SCREEN_HEIGHT << FRACTION_BITS) - 1);
  localparam logic [ACC_W-1:0] ORIGIN_U = ACC_W'(HALF_W << FRACTION_BITS);
  localparam logic [ACC_W-1:0] ORIGIN_V = ACC_W'(HALF_H << FRACTION_BITS);
  localparam logic [QW:0]      W_M1     = (QW + 1)'(SCREEN_WIDTH - 1);

  // configuration register map, byte addressed
  localparam int ADDR_W = 3;
  localparam logic REG_STEP_U = 1'b0;
  localparam logic REG_STEP_V = 1'b1;

  typedef struct packed {
    logic          ok;
    logic [QW:0]   lo;
    logic [QW:0]   hi;
  } span_t;

endpackage

@@ design/rotozoom_row_span_setup.sv @@
// Row span setup for a rotate-and-zoom texture mapper.
// Input stream: one transaction per screen row; in_tdata[0] = restart starts a
// new frame at row 0 from the centred origin, 0 asks for the next row.
// Output stream: one transaction per input transaction carrying the row index,
// a visible flag, first/last visible column and texture u (9.8) and v (8.8) at the first
// column (all zero when the row is not visible).
// Configuration: APB port, step_u_per_pixel at address 0, step_v_per_pixel at
// address 4; write them only while no row is in flight.
// Timing: one shared restoring divider runs four divisions per row (QW = 9
// steps each, skipped when the quotient saturates), plus one shared
// multiply-accumulate for the origin on restart and for u/v at the first
// column. The next row is accepted once the block is back in idle.
// Reset: steps return to du = 1.0, dv = 0, accumulators and row counter clear.
// Stall: a finished result waits in the output register; the block accepts the
// next row meanwhile and holds its own next result until the register frees.
module rotozoom_row_span_setup (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] restart, [7:1] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [7:0] row, [8] visible, [17:9] first_x, [26:18] last_x,
  //            [43:27] u_first, [59:44] v_first, [63:60] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ACC_W  = rzspan_pkg::ACC_W;
  localparam int STEP_W = rzspan_pkg::STEP_W;
  localparam int QW     = rzspan_pkg::QW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;
  localparam logic [2:0] S_COMB  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // multiply-accumulate steps
  localparam logic [2:0] MAC_U_DU = 3'd0;
  localparam logic [2:0] MAC_U_DV = 3'd1;
  localparam logic [2:0] MAC_V_DV = 3'd2;
  localparam logic [2:0] MAC_V_DU = 3'd3;
  localparam logic [2:0] MAC_UF   = 3'd4;
  localparam logic [2:0] MAC_VF   = 3'd5;

  localparam logic [1:0] DIV_LAST = 2'd3;

  logic [2:0]               state_r;
  logic signed [STEP_W-1:0] step_u_r;
  logic signed [STEP_W-1:0] step_v_r;
  logic [ACC_W-1:0]         row_u_acc_r;
  logic [ACC_W-1:0]         row_v_acc_r;
  logic [rzspan_pkg::ROW_W-1:0] row_counter_r;
  logic [2:0]               k_r;
  logic [1:0]               div_r;
  logic [ACC_W-1:0]         dvd_r;
  logic [STEP_W-1:0]        dsr_r;
  logic                     ceil_r;
  logic                     sat_r;
  logic [STEP_W-1:0]        rem_r;
  logic [QW-1:0]            nlo_r;
  logic [QW-1:0]            quo_r;
  logic [rzspan_pkg::CNT_W-1:0] cnt_r;
  logic [QW:0]              qd_r [4];
  logic [QW:0]              first_r;
  logic [QW:0]              last_r;
  logic                     vis_r;
  logic [rzspan_pkg::UF_W-1:0] uf_r;
  logic [rzspan_pkg::VF_W-1:0] vf_r;
  logic                     out_tvalid_r;
  logic [63:0]              out_tdata_r;

  // ---------------------------------------------------------------- config
  logic cfg_wr;
  logic cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[rzspan_pkg::ADDR_W-1];

  always_comb begin
    case (cfg_idx)
      rzspan_pkg::REG_STEP_U: prdata = {21'd0, step_u_r};
      rzspan_pkg::REG_STEP_V: prdata = {21'd0, step_v_r};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------- shared MAC unit
  logic signed [STEP_W-1:0]                 mul_a;
  logic [rzspan_pkg::MUL_B_W-1:0]           mul_b;
  logic [ACC_W-1:0]                         mac_base;
  logic                                     mac_sub;
  logic signed [rzspan_pkg::PROD_W-1:0]     mac_prod;
  logic [ACC_W-1:0]                         mac_ext;
  logic [ACC_W-1:0]                         mac_sum;

  always_comb begin
    case (k_r)
      MAC_U_DU: begin
        mul_a = step_u_r; mul_b = rzspan_pkg::MUL_B_W'(rzspan_pkg::HALF_W);
        mac_base = row_u_acc_r; mac_sub = 1'b1;
      end
      MAC_U_DV: begin
        mul_a = step_v_r; mul_b = rzspan_pkg::MUL_B_W'(rzspan_pkg::HALF_H);
        mac_base = row_u_acc_r; mac_sub = 1'b0;
      end
      MAC_V_DV: begin
        mul_a = step_v_r; mul_b = rzspan_pkg::MUL_B_W'(rzspan_pkg::HALF_W);
        mac_base = row_v_acc_r; mac_sub = 1'b1;
      end
      MAC_V_DU: begin
        mul_a = step_u_r; mul_b = rzspan_pkg::MUL_B_W'(rzspan_pkg::HALF_H);
        mac_base = row_v_acc_r; mac_sub = 1'b1;
      end
      MAC_UF: begin
        mul_a = step_u_r; mul_b = rzspan_pkg::MUL_B_W'(first_r);
        mac_base = row_u_acc_r; mac_sub = 1'b0;
      end
      MAC_VF: begin
        mul_a = step_v_r; mul_b = rzspan_pkg::MUL_B_W'(first_r);
        mac_base = row_v_acc_r; mac_sub = 1'b0;
      end
      default: begin
        mul_a = '0; mul_b = '0; mac_base = '0; mac_sub = 1'b0;
      end
    endcase
  end

  assign mac_prod = rzspan_pkg::PROD_W'(mul_a) *
                    rzspan_pkg::PROD_W'($signed({1'b0, mul_b}));
  assign mac_ext  = {{(ACC_W - rzspan_pkg::PROD_W){mac_prod[rzspan_pkg::PROD_W-1]}},
                     mac_prod};
  assign mac_sum  = mac_sub ? (mac_base - mac_ext) : (mac_base + mac_ext);

  // ------------------------------------------------ divider operand setup
  // div_r[1] picks the axis (u, v), div_r[0] picks low bound or high bound
  logic [ACC_W-1:0]  ld_s;
  logic [STEP_W-1:0] ld_t;
  logic [ACC_W-1:0]  ld_lm1;
  logic [ACC_W-1:0]  ld_dvd;
  logic [STEP_W-1:0] ld_dsr;

  always_comb begin
    ld_s   = div_r[1] ? row_v_acc_r : row_u_acc_r;
    ld_t   = div_r[1] ? step_v_r : step_u_r;
    ld_lm1 = div_r[1] ? rzspan_pkg::LIM_V_M1 : rzspan_pkg::LIM_U_M1;
    if (!div_r[0]) begin
      ld_dvd = ld_t[STEP_W-1] ? (ld_s - ld_lm1) : (ACC_W'(0) - ld_s);
    end else begin
      ld_dvd = ld_t[STEP_W-1] ? ld_s : (ld_lm1 - ld_s);
    end
    ld_dsr = ld_t[STEP_W-1] ? (STEP_W'(0) - ld_t) : ld_t;
  end

  logic [ACC_W:0]    sat_lim;
  logic              chk_sat;
  logic [STEP_W:0]   trial;
  logic              trial_ge;
  logic [QW:0]       quo_fin;

  assign sat_lim  = (ACC_W + 1)'({dsr_r, {QW{1'b0}}});
  assign chk_sat  = {1'b0, dvd_r} >= sat_lim;
  assign trial    = {rem_r, nlo_r[QW-1]};
  assign trial_ge = trial >= {1'b0, dsr_r};
  assign quo_fin  = sat_r ? (QW + 1)'(1 << QW)
                          : ({1'b0, quo_r} + (QW + 1)'(ceil_r && (rem_r != '0)));

  // --------------------------------------------------------- span combine
  function automatic rzspan_pkg::span_t span_of(
    input logic [ACC_W-1:0]  s,
    input logic [STEP_W-1:0] t,
    input logic [ACC_W-1:0]  lm1,
    input logic [QW:0]       qa,
    input logic [QW:0]       qb
  );
    rzspan_pkg::span_t r;
    logic s_neg;
    logic s_hi;
    logic [QW:0] hic;
    s_neg = s[ACC_W-1];
    s_hi  = !s_neg && (s > lm1);
    hic   = (qb > rzspan_pkg::W_M1) ? rzspan_pkg::W_M1 : qb;
    if (t == '0) begin
      r.ok = !s_neg && !s_hi;
      r.lo = '0;
      r.hi = rzspan_pkg::W_M1;
    end else if (!t[STEP_W-1]) begin
      r.ok = !s_hi;
      r.lo = s_neg ? qa : '0;
      r.hi = hic;
    end else begin
      r.ok = !s_neg;
      r.lo = s_hi ? qa : '0;
      r.hi = hic;
    end
    r.ok = r.ok && (r.lo <= r.hi);
    return r;
  endfunction

  rzspan_pkg::span_t span_u;
  rzspan_pkg::span_t span_v;
  logic [QW:0] cmb_first;
  logic [QW:0] cmb_last;
  logic        cmb_vis;

  always_comb begin
    span_u    = span_of(row_u_acc_r, step_u_r, rzspan_pkg::LIM_U_M1, qd_r[0], qd_r[1]);
    span_v    = span_of(row_v_acc_r, step_v_r, rzspan_pkg::LIM_V_M1, qd_r[2], qd_r[3]);
    cmb_first = (span_v.lo > span_u.lo) ? span_v.lo : span_u.lo;
    cmb_last  = (span_v.hi < span_u.hi) ? span_v.hi : span_u.hi;
    cmb_vis   = span_u.ok && span_v.ok && (cmb_first <= cmb_last);
  end

  // ------------------------------------------------------------ sequencer
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      step_u_r      <= STEP_W'(256);
      step_v_r      <= '0;
      row_u_acc_r   <= '0;
      row_v_acc_r   <= '0;
      row_counter_r <= '0;
      k_r           <= MAC_U_DU;
      div_r         <= '0;
      cnt_r         <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          rzspan_pkg::REG_STEP_U: step_u_r <= pwdata[STEP_W-1:0];
          rzspan_pkg::REG_STEP_V: step_v_r <= pwdata[STEP_W-1:0];
          default: ;
        endcase
      end
      // in done the register is reloaded instead
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            div_r <= '0;
            if (in_tdata[0]) begin
              row_u_acc_r   <= rzspan_pkg::ORIGIN_U;
              row_v_acc_r   <= rzspan_pkg::ORIGIN_V;
              row_counter_r <= '0;
              k_r           <= MAC_U_DU;
              state_r       <= S_MAC;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_MAC: begin
          case (k_r)
            MAC_U_DU, MAC_U_DV: row_u_acc_r <= mac_sum;
            MAC_V_DV, MAC_V_DU: row_v_acc_r <= mac_sum;
            MAC_UF:             uf_r <= mac_sum[rzspan_pkg::UF_W-1:0];
            MAC_VF:             vf_r <= mac_sum[rzspan_pkg::VF_W-1:0];
            default: ;
          endcase
          k_r <= k_r + 3'd1;
          if (k_r == MAC_V_DU) begin
            state_r <= S_LOAD;
          end else if (k_r == MAC_VF) begin
            state_r <= S_DONE;
          end
        end
        S_LOAD: begin
          dvd_r   <= ld_dvd;
          dsr_r   <= ld_dsr;
          ceil_r  <= !div_r[0];
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          // quotient of 2**QW or more lies off screen: skip the steps
          sat_r   <= chk_sat;
          rem_r   <= STEP_W'(dvd_r >> QW);
          nlo_r   <= dvd_r[QW-1:0];
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= chk_sat ? S_STORE : S_DIV;
        end
        S_DIV: begin
          rem_r <= trial_ge ? STEP_W'(trial - {1'b0, dsr_r}) : STEP_W'(trial);
          quo_r <= {quo_r[QW-2:0], trial_ge};
          nlo_r <= {nlo_r[QW-2:0], 1'b0};
          cnt_r <= cnt_r + rzspan_pkg::CNT_W'(1);
          if (cnt_r == rzspan_pkg::CNT_W'(QW - 1)) begin
            state_r <= S_STORE;
          end
        end
        S_STORE: begin
          qd_r[div_r] <= quo_fin;
          div_r       <= div_r + 2'd1;
          state_r     <= (div_r == DIV_LAST) ? S_COMB : S_LOAD;
        end
        S_COMB: begin
          vis_r   <= cmb_vis;
          first_r <= cmb_vis ? cmb_first : '0;
          last_r  <= cmb_vis ? cmb_last : '0;
          k_r     <= MAC_UF;
          state_r <= S_MAC;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {4'd0,
                             vis_r ? vf_r : rzspan_pkg::VF_W'(0),
                             vis_r ? uf_r : rzspan_pkg::UF_W'(0),
                             rzspan_pkg::X_W'(last_r),
                             rzspan_pkg::X_W'(first_r),
                             vis_r,
                             row_counter_r};
            row_u_acc_r   <= row_u_acc_r - {{(ACC_W - STEP_W){step_v_r[STEP_W-1]}}, step_v_r};
            row_v_acc_r   <= row_v_acc_r + {{(ACC_W - STEP_W){step_u_r[STEP_W-1]}}, step_u_r};
            row_counter_r <= row_counter_r + rzspan_pkg::ROW_W'(1);
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ----------------------------------------------------------- assertions
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("block ready right after accepting a row");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < dsr_r)
    else $error("divider remainder not below divisor");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[59:9] == '0)
    else $error("hidden row carries nonzero span fields");

  a_visible_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |->
      out_tdata[17:9] <= out_tdata[26:18] &&
      out_tdata[26:18] <= rzspan_pkg::X_W'(rzspan_pkg::SCREEN_WIDTH - 1))
    else $error("visible span out of order or off screen");

endmodule

@@ verif/span_checker.sv @@
`timescale 1ns / 1ps

module span_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // in_tdata: [0] restart, [7:1] zero
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: [7:0] row, [8] visible, [17:9] first_x, [26:18] last_x,
  //            [43:27] u_first, [59:44] v_first, [63:60] zero
  input  logic [63:0] out_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          spans_pending,
  output int          rows_checked,
  output int          visible_rows,
  output int          frame_restarts
);

  localparam longint WIDTH_PX    = 320;
  localparam longint HEIGHT_PX   = 200;
  localparam longint FRAC        = 8;
  localparam longint TEX_U_LIMIT = WIDTH_PX << FRAC;
  localparam longint TEX_V_LIMIT = HEIGHT_PX << FRAC;

  typedef struct packed {
    logic [15:0] v_first;
    logic [16:0] u_first;
    logic [8:0]  last_x;
    logic [8:0]  first_x;
    logic        visible;
    logic [7:0]  row;
  } row_span_t;

  logic signed [10:0] step_u;
  logic signed [10:0] step_v;
  logic signed [23:0] row_u;
  logic signed [23:0] row_v;
  logic [7:0]         row_idx;
  row_span_t          spans_due[$];

  // Columns where 0 <= start + x*step < limit, clamped to the screen.
  function automatic bit axis_range(input longint start, input longint step,
                                    input longint limit,
                                    output longint lo, output longint hi);
    longint a, b, d;
    lo = 0;
    hi = 0;
    if (step == 0) begin
      if (start >= 0 && start < limit) begin
        hi = WIDTH_PX - 1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (step > 0) begin
      a = (start >= 0) ? 0 : ((-start) + step - 1) / step;
      if (start > limit - 1)
        return 1'b0;
      b = (limit - 1 - start) / step;
    end else begin
      d = -step;
      if (start < 0)
        return 1'b0;
      b = start / d;
      a = (start <= limit - 1) ? 0 : ((start - (limit - 1)) + d - 1) / d;
    end
    if (a < 0)
      a = 0;
    if (b > WIDTH_PX - 1)
      b = WIDTH_PX - 1;
    if (a > b)
      return 1'b0;
    lo = a;
    hi = b;
    return 1'b1;
  endfunction

  // Span of the current row, then advance the row accumulators.
  function automatic row_span_t next_span(input bit restart);
    longint    du, dv, ru, rv, fu, lu, fv, lv, first, last;
    bit        vis;
    row_span_t rec;
    du = step_u;
    dv = step_v;
    first = 0;
    last = 0;
    vis = 1'b0;
    if (restart) begin
      row_u = 24'(((WIDTH_PX / 2) << FRAC) - du * (WIDTH_PX / 2) + dv * (HEIGHT_PX / 2));
      row_v = 24'(((HEIGHT_PX / 2) << FRAC) - dv * (WIDTH_PX / 2) - du * (HEIGHT_PX / 2));
      row_idx = '0;
    end
    ru = row_u;
    rv = row_v;
    if (axis_range(ru, du, TEX_U_LIMIT, fu, lu) && axis_range(rv, dv, TEX_V_LIMIT, fv, lv)) begin
      first = (fv > fu) ? fv : fu;
      last = (lv < lu) ? lv : lu;
      vis = (first <= last);
    end
    rec = '0;
    rec.row = row_idx;
    rec.visible = vis;
    if (vis) begin
      rec.first_x = 9'(first);
      rec.last_x = 9'(last);
      rec.u_first = 17'(ru + du * first);
      rec.v_first = 16'(rv + dv * first);
    end
    row_u = 24'(ru - dv);
    row_v = 24'(rv + du);
    row_idx = row_idx + 8'd1;
    return rec;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    row_span_t got, want;
    if (!rst_n) begin
      step_u = 11'sd256;
      step_v = '0;
      row_u = '0;
      row_v = '0;
      row_idx = '0;
      spans_due.delete();
      mismatches = 0;
      rows_checked = 0;
      visible_rows = 0;
      frame_restarts = 0;
    end else begin
      // retire first: a result never belongs to a row accepted at the same edge
      if (out_tvalid && out_tready) begin
        got = out_tdata[59:0];
        if (spans_due.size() == 0) begin
          mismatches++;
          $display("%0t: span expected none, got row %0d visible %0d", $time,
                   got.row, got.visible);
        end else begin
          want = spans_due.pop_front();
          check_field("row", want.row, got.row);
          check_field("visible", want.visible, got.visible);
          check_field("first_x", want.first_x, got.first_x);
          check_field("last_x", want.last_x, got.last_x);
          check_field("u_first", want.u_first, got.u_first);
          check_field("v_first", want.v_first, got.v_first);
          rows_checked++;
          if (want.visible)
            visible_rows++;
        end
      end
      if (in_tvalid && in_tready) begin
        spans_due.push_back(next_span(in_tdata[0]));
        if (in_tdata[0])
          frame_restarts++;
      end
      // new steps apply from the next row
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == rzspan_pkg::REG_STEP_U)
          step_u = pwdata[10:0];
        else
          step_v = pwdata[10:0];
      end
    end
    spans_pending <= spans_due.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int PHASES         = 12;
  localparam int ROWS_PER_PHASE = 150;
  localparam int OUT_HOLD_OFF   = 400;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int         mismatches;
  int         spans_pending;
  int         rows_checked;
  int         visible_rows;
  int         frame_restarts;
  idle_mode_t idle_mode;
  bit         squeeze_out;

  rotozoom_row_span_setup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  span_checker span_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .spans_pending  (spans_pending),
    .rows_checked   (rows_checked),
    .visible_rows   (visible_rows),
    .frame_restarts (frame_restarts)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d spans outstanding", cycles, spans_pending);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int idle_pct(input idle_mode_t m, input bit receiver_side);
    case (m)
      IDLE_SENDER:   return receiver_side ? 0 : 58;
      IDLE_RECEIVER: return receiver_side ? 58 : 0;
      IDLE_BOTH:     return 13;
      default:       return 0;
    endcase
  endfunction

  function automatic int pick_step();
    case ($urandom_range(7))
      0:       return -512;
      1:       return 512;
      2:       return 0;
      3:       return $urandom_range(1) ? 1 : -1;
      default: return int'($urandom_range(1024)) - 512;
    endcase
  endfunction

  function automatic int pick_frame();
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(100, 1);
      3, 4:    return $urandom_range(300, 257);
      default: return 200;
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off when asked
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_out && !held) begin
        held = 1'b1;
        hold_left = OUT_HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b1));
      end
    end
  end

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic send_row(input bit restart);
    while ($urandom_range(99) < idle_pct(idle_mode, 1'b0)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, restart};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait until every outstanding span has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (spans_pending != 0)
      @(negedge clk);
  endtask

  task automatic write_step(input logic idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int frame_left;
    int settings;
    int du, dv;
    in_tvalid = 1'b0;
    in_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_mode = IDLE_NONE;
    squeeze_out = 1'b0;
    settings = 1;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // rows before any restart work from zero accumulators
    send_row(1'b0);
    send_row(1'b0);
    send_row(1'b1);
    repeat (3) send_row(1'b0);

    drain();
    write_step(rzspan_pkg::REG_STEP_U, 512);
    write_step(rzspan_pkg::REG_STEP_V, -512);
    settings++;
    send_row(1'b1);
    repeat (3) send_row(1'b0);

    drain();
    write_step(rzspan_pkg::REG_STEP_U, -512);
    write_step(rzspan_pkg::REG_STEP_V, 512);
    settings++;
    send_row(1'b1);
    repeat (2) send_row(1'b0);

    // both steps zero: whole row
    drain();
    write_step(rzspan_pkg::REG_STEP_U, 0);
    write_step(rzspan_pkg::REG_STEP_V, 0);
    settings++;
    send_row(1'b1);
    send_row(1'b0);

    // zero u step with u off the image: nothing
    drain();
    write_step(rzspan_pkg::REG_STEP_V, 512);
    settings++;
    send_row(1'b1);
    send_row(1'b0);

    // zero v step with v off the image: nothing
    drain();
    write_step(rzspan_pkg::REG_STEP_U, 512);
    write_step(rzspan_pkg::REG_STEP_V, 0);
    settings++;
    send_row(1'b1);
    send_row(1'b0);

    // change steps mid-frame: accumulators carry on
    drain();
    write_step(rzspan_pkg::REG_STEP_U, 1);
    write_step(rzspan_pkg::REG_STEP_V, -1);
    settings++;
    send_row(1'b0);
    send_row(1'b0);
    send_row(1'b1);

    frame_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      squeeze_out = 1'b0;
      du = pick_step();
      dv = pick_step();
      case ($urandom_range(3))
        0: write_step(rzspan_pkg::REG_STEP_U, du);
        1: write_step(rzspan_pkg::REG_STEP_V, dv);
        default: begin
          write_step(rzspan_pkg::REG_STEP_U, du);
          write_step(rzspan_pkg::REG_STEP_V, dv);
        end
      endcase
      settings++;
      idle_mode = idle_mode_t'(ph % 4);
      squeeze_out = (ph == 4);
      for (int n = 0; n < ROWS_PER_PHASE; n++) begin
        // mostly whole frames, with the odd early restart
        if (frame_left == 0 || $urandom_range(49) == 0) begin
          send_row(1'b1);
          frame_left = pick_frame();
        end else begin
          send_row(1'b0);
          frame_left--;
        end
      end
    end

    drain();
    repeat (60) @(negedge clk);
    $display("Checked %0d row spans (%0d visible, %0d frame restarts) over %0d step settings",
             rows_checked, visible_rows, frame_restarts, settings);
    $display("Traffic ran with no idling, sender gaps, receiver stalls, both, and one long hold-off");
    if (mismatches == 0 && spans_pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
